// ===== hdl/dcma_pkg.sv =====
package dcma_pkg;

	// Field and register widths
	localparam int SAMPLE_W  = 24;
	localparam int TPM_W     = 23;
	localparam int TOTAL_W   = 32;
	localparam int SUM_W     = 25;
	localparam int CFG_IDX_W = 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RELOAD_VALUE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS = CFG_IDX_W'(1);

	// Register reset values
	localparam logic [SAMPLE_W-1:0] RELOAD_RESET = SAMPLE_W'(999);
	localparam logic [TPM_W-1:0]    TPM_RESET    = TPM_W'(1000);

	// Divider sequencing: one quotient bit per step
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [TPM_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SUM_W-1:0]  quotient;
		logic [TPM_W-1:0]  remainder;
	} div_resp_t;

endpackage

// ===== hdl/dcma_if.sv =====
interface dcma_sample_if import dcma_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] counter_sample;

	modport source (output valid, output counter_sample, input ready);
	modport sink   (input valid, input counter_sample, output ready);
endinterface

interface dcma_result_if import dcma_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] total_ms;
	logic [SUM_W-1:0]   ms_step;

	modport source (output valid, output total_ms, output ms_step, input ready);
	modport sink   (input valid, input total_ms, input ms_step, output ready);
endinterface

interface dcma_cfg_if import dcma_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/dcma_div.sv =====
module dcma_div import dcma_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_resp_t resp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [TPM_W-1:0]  rem_q;
	logic [TPM_W-1:0]  dsr_q;

	logic [TPM_W:0]    trial;
	logic [TPM_W:0]    diff;
	logic              ge;
	logic [TPM_W-1:0]  rem_next;

	// Restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, dvd_q[SUM_W-1]};
		diff     = trial - {1'b0, dsr_q};
		ge       = (trial >= {1'b0, dsr_q});
		rem_next = ge ? diff[TPM_W-1:0] : trial[TPM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign resp.done      = done_q;
	assign resp.quotient  = dvd_q;
	assign resp.remainder = rem_q;

endmodule

// ===== hdl/down_counter_ms_accumulator.sv =====
// The sample beat loads the divider, which runs 25 divide steps, and the
// result is then loaded into the output register.
// No new sample is taken until the bit-serial divider's result is loaded.
// A pending result may wait at the output while the next sample divides.
// Reset (arst_n low, asynchronous): registers return to 999 / 1000,
// previous sample, tick remainder and millisecond total clear to zero.
module down_counter_ms_accumulator import dcma_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	dcma_cfg_if.sink      cfg,
	dcma_sample_if.sink   sample,
	dcma_result_if.source result
);

	// Configuration registers
	logic [SAMPLE_W-1:0] reload_q;
	logic [TPM_W-1:0]    tpm_q;

	// Running state
	logic [SAMPLE_W-1:0] prev_q;
	logic [TPM_W-1:0]    rem_q;
	logic [TOTAL_W-1:0]  total_q;

	// Output register
	logic                out_valid_q;
	logic [TOTAL_W-1:0]  out_total_q;
	logic [SUM_W-1:0]    out_step_q;

	state_t state_q, state_d;

	div_req_t  div_req;
	div_resp_t div_resp;

	logic                in_beat;
	logic                out_free;
	logic                load_out;
	logic [SUM_W-1:0]    period;
	logic [SUM_W-1:0]    wrapped;
	logic [SAMPLE_W-1:0] elapsed;
	logic [TPM_W-1:0]    divisor;
	logic [TOTAL_W-1:0]  total_next;

	// Configuration must be written only while idle (the block does not enforce this), so take it at once
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_RESET;
			tpm_q    <= TPM_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_RELOAD_VALUE: reload_q <= cfg.data[SAMPLE_W-1:0];
				REG_TICKS_PER_MS: tpm_q    <= cfg.data[TPM_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// Elapsed ticks: plain difference, or once round the period when the
	// counter has reloaded; keep 24 bits so out-of-range samples wrap.
	always_comb begin
		period  = {1'b0, reload_q} + SUM_W'(1);
		wrapped = {1'b0, prev_q} + period - {1'b0, sample.counter_sample};
		if (prev_q >= sample.counter_sample) begin
			elapsed = prev_q - sample.counter_sample;
		end else begin
			elapsed = wrapped[SAMPLE_W-1:0];
		end
		divisor = (tpm_q == '0) ? TPM_W'(1) : tpm_q;
	end

	assign in_beat = sample.valid && sample.ready;

	// Start the divider on the beat itself: dividend is remainder + elapsed
	assign div_req.start    = in_beat;
	assign div_req.dividend = {2'b00, rem_q} + {1'b0, elapsed};
	assign div_req.divisor  = divisor;

	dcma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.resp   (div_resp)
	);

	// The output register is free when empty or being drained this cycle
	assign out_free   = !out_valid_q || result.ready;
	assign total_next = total_q + {{(TOTAL_W-SUM_W){1'b0}}, div_resp.quotient};

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (div_resp.done) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				// divider holds its result until the output drains
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign sample.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			rem_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_beat) begin
				prev_q <= sample.counter_sample;
			end
			// Commit remainder and total only when the result is handed on
			if (load_out) begin
				rem_q       <= div_resp.remainder;
				total_q     <= total_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_total_q <= total_next;
			out_step_q  <= div_resp.quotient;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.total_ms = out_total_q;
	assign result.ms_step  = out_step_q;

endmodule

// ===== hdl/dcma_checker.sv =====
module dcma_checker import dcma_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [TOTAL_W-1:0] total_ms,
	input logic [SUM_W-1:0]   ms_step
);

	logic [TOTAL_W-1:0] last_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (out_valid && out_ready) begin
			last_total_q <= total_ms;
		end
	end

	// Busy for the whole division once a sample is taken
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while a division runs");

	// Each beat moves the total on by exactly its step
	a_total_tracks_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |->
			total_ms == last_total_q + {{(TOTAL_W-SUM_W){1'b0}}, ms_step})
		else $error("total does not match previous total plus step");

	// A fresh result leaves the block idle and ready
	a_ready_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while block still busy");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_ms) && $stable(ms_step))
		else $error("stalled result changed");

endmodule

bind down_counter_ms_accumulator dcma_checker u_dcma_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.total_ms  (result.total_ms),
	.ms_step   (result.ms_step)
);
